/* rtl/sot_pkg.sv */
// Package for the stack offset tracker: widths, decode patterns and limits.
package sot_pkg;

   // Width of the running and lowest offset accumulators.
   localparam int OFFSET_WIDTH = 32;

   // Width of the reported offset field.
   localparam int REPORT_WIDTH = 32;

   // Width used to compare an accumulator value against the reported range.
   localparam int EXT_WIDTH = (OFFSET_WIDTH > REPORT_WIDTH) ? OFFSET_WIDTH : REPORT_WIDTH;

   // Width of the magnitude of one stack adjustment (12-bit ARM immediate at most).
   localparam int DELTA_WIDTH = 13;

   // ARM decode patterns.
   localparam logic [15:0] ARM_PUSH_TOP = 16'hE92D;
   localparam logic [15:0] ARM_POP_TOP  = 16'hE8BD;
   localparam logic [1:0]  ARM_DP_GROUP = 2'b00;
   localparam logic [3:0]  ARM_OP_ADD   = 4'd4;
   localparam logic [3:0]  ARM_OP_SUB   = 4'd2;
   localparam logic [3:0]  ARM_REG_SP   = 4'd13;

   // Thumb decode patterns.
   localparam logic [6:0]  THUMB_PUSH_HI7 = 7'b1011010;
   localparam logic [6:0]  THUMB_POP_HI7  = 7'b1011110;
   localparam logic [8:0]  THUMB_ADD_HI9  = 9'b101100000;
   localparam logic [8:0]  THUMB_SUB_HI9  = 9'b101100001;

   // Saturation limits of the accumulator, one bit wider than it.
   localparam logic signed [OFFSET_WIDTH:0] SUM_MAX =
      {2'b00, {(OFFSET_WIDTH-1){1'b1}}};
   localparam logic signed [OFFSET_WIDTH:0] SUM_MIN =
      {2'b11, {(OFFSET_WIDTH-1){1'b0}}};

   // Limits of the reported 32-bit field, widened for comparison.
   localparam logic signed [EXT_WIDTH-1:0] REPORT_MAX = EXT_WIDTH'(32'sh7FFF_FFFF);
   localparam logic signed [EXT_WIDTH-1:0] REPORT_MIN = EXT_WIDTH'(32'sh8000_0000);

endpackage

/* rtl/stack_offset_tracker.sv */
// Top level of the stack offset tracker: decode, accumulate and report per range.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | instruction_word, arm_sel, last_in_range
//   rsp     | out       | rsp_valid/rsp_stall | stack_offset, pc_was_popped, saturated
//
// One instruction word is taken per cycle while req_stall is low; a result is registered
// when its last word drains, as the input register hands over to the result register.
// Reset clears the accumulators, the flags and both valid registers.
// Words that are not last keep flowing while a result waits; only a last word
// waits in the input register until the result register is free.
module stack_offset_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instruction_word,
   input  logic        req_arm_sel,
   input  logic        req_last_in_range,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_stack_offset,
   output logic        rsp_pc_was_popped,
   output logic        rsp_saturated
);

   localparam int OW = sot_pkg::OFFSET_WIDTH;

   // Input register.
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_word_ff;
   logic        s1_arm_ff;
   logic        s1_last_ff;

   // Accumulator state.
   logic signed [OW-1:0] run_ff, run_in;
   logic signed [OW-1:0] low_ff, low_in;
   logic                 pc_ff, pc_in;
   logic                 clip_ff, clip_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_offset_ff;
   logic               rsp_pc_ff;
   logic               rsp_sat_ff;

   logic req_transfer;
   logic drain;

   logic [sot_pkg::DELTA_WIDTH-1:0] delta_mag;
   logic                            delta_neg;
   logic                            pop_pc;
   logic signed [OW:0]              delta_ext;
   logic signed [OW:0]              sum;
   logic signed [OW-1:0]            run_next;
   logic                            clip_now;
   logic signed [OW-1:0]            low_next;
   logic                            pc_next;
   logic signed [OW-1:0]            report;
   logic signed [sot_pkg::EXT_WIDTH-1:0] report_ext;
   logic signed [31:0]              report_out;
   logic                            report_clip;

   logic [15:0] half;
   logic [4:0]  arm_count;
   logic [3:0]  thumb_count;

   // Ones count of a nibble.
   function automatic logic [2:0] pop4(input logic [3:0] v);
      pop4 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
   endfunction

   // Handshake: the input register empties when its item can move on.
   always_comb begin
      drain        = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
      req_stall    = s1_valid_ff && !drain;
      req_transfer = req_valid && !req_stall;
      s1_valid_in  = req_transfer ? 1'b1 : (drain ? 1'b0 : s1_valid_ff);
   end

   // Register counts for push and pop lists.
   always_comb begin
      half        = s1_word_ff[15:0];
      arm_count   = 5'(pop4(half[3:0])) + 5'(pop4(half[7:4]))
                  + 5'(pop4(half[11:8])) + 5'(pop4(half[15:12]));
      thumb_count = 4'(pop4(half[3:0])) + 4'(pop4(half[7:4])) + 4'(half[8]);
   end

   // Decode the word into a signed stack adjustment.
   always_comb begin
      delta_mag = '0;
      delta_neg = 1'b0;
      pop_pc    = 1'b0;
      if (s1_arm_ff) begin
         priority if (s1_word_ff[31:16] == sot_pkg::ARM_PUSH_TOP) begin
            delta_mag = sot_pkg::DELTA_WIDTH'({arm_count, 2'b00});
            delta_neg = 1'b1;
         end else if (s1_word_ff[31:16] == sot_pkg::ARM_POP_TOP) begin
            delta_mag = sot_pkg::DELTA_WIDTH'({arm_count, 2'b00});
            pop_pc    = s1_word_ff[15];
         end else if (s1_word_ff[27:26] == sot_pkg::ARM_DP_GROUP
                      && s1_word_ff[24:21] == sot_pkg::ARM_OP_ADD
                      && s1_word_ff[15:12] == sot_pkg::ARM_REG_SP) begin
            delta_mag = sot_pkg::DELTA_WIDTH'(s1_word_ff[11:0]);
         end else if (s1_word_ff[27:26] == sot_pkg::ARM_DP_GROUP
                      && s1_word_ff[24:21] == sot_pkg::ARM_OP_SUB
                      && s1_word_ff[15:12] == sot_pkg::ARM_REG_SP) begin
            delta_mag = sot_pkg::DELTA_WIDTH'(s1_word_ff[11:0]);
            delta_neg = 1'b1;
         end else begin
            delta_mag = '0;
         end
      end else begin
         priority if (half[15:9] == sot_pkg::THUMB_PUSH_HI7) begin
            delta_mag = sot_pkg::DELTA_WIDTH'({thumb_count, 2'b00});
            delta_neg = 1'b1;
         end else if (half[15:9] == sot_pkg::THUMB_POP_HI7) begin
            delta_mag = sot_pkg::DELTA_WIDTH'({thumb_count, 2'b00});
            pop_pc    = half[8];
         end else if (half[15:7] == sot_pkg::THUMB_ADD_HI9) begin
            delta_mag = sot_pkg::DELTA_WIDTH'({half[6:0], 2'b00});
         end else if (half[15:7] == sot_pkg::THUMB_SUB_HI9) begin
            delta_mag = sot_pkg::DELTA_WIDTH'({half[6:0], 2'b00});
            delta_neg = 1'b1;
         end else begin
            delta_mag = '0;
         end
      end
   end

   // Saturating accumulate, lowest offset and the value to report.
   always_comb begin
      delta_ext = delta_neg ? -$signed({1'b0, (OW)'(delta_mag)})
                            :  $signed({1'b0, (OW)'(delta_mag)});
      sum       = $signed({run_ff[OW-1], run_ff}) + delta_ext;
      clip_now  = 1'b0;
      if (sum > sot_pkg::SUM_MAX) begin
         run_next = sot_pkg::SUM_MAX[OW-1:0];
         clip_now = 1'b1;
      end else if (sum < sot_pkg::SUM_MIN) begin
         run_next = sot_pkg::SUM_MIN[OW-1:0];
         clip_now = 1'b1;
      end else begin
         run_next = sum[OW-1:0];
      end
      low_next = (run_next < low_ff) ? run_next : low_ff;
      pc_next  = pc_ff || pop_pc;

      report      = (!run_next[OW-1] && pc_next) ? low_next : run_next;
      report_ext  = sot_pkg::EXT_WIDTH'(report);
      report_clip = 1'b0;
      if (report_ext > sot_pkg::REPORT_MAX) begin
         report_out  = 32'sh7FFF_FFFF;
         report_clip = 1'b1;
      end else if (report_ext < sot_pkg::REPORT_MIN) begin
         report_out  = 32'sh8000_0000;
         report_clip = 1'b1;
      end else begin
         report_out  = report_ext[31:0];
      end
   end

   // Next accumulator state: cleared after the last word of a range.
   always_comb begin
      run_in  = run_ff;
      low_in  = low_ff;
      pc_in   = pc_ff;
      clip_in = clip_ff;
      if (drain) begin
         if (s1_last_ff) begin
            run_in  = '0;
            low_in  = '0;
            pc_in   = 1'b0;
            clip_in = 1'b0;
         end else begin
            run_in  = run_next;
            low_in  = low_next;
            pc_in   = pc_next;
            clip_in = clip_ff || clip_now;
         end
      end
   end

   // Result valid: set by a draining last word, cleared by a transfer.
   always_comb begin
      if (drain && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and accumulator registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
         low_ff       <= '0;
         pc_ff        <= 1'b0;
         clip_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         run_ff       <= run_in;
         low_ff       <= low_in;
         pc_ff        <= pc_in;
         clip_ff      <= clip_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_word_ff <= req_instruction_word;
         s1_arm_ff  <= req_arm_sel;
         s1_last_ff <= req_last_in_range;
      end
      if (drain && s1_last_ff) begin
         rsp_offset_ff <= report_out;
         rsp_pc_ff     <= pc_next;
         rsp_sat_ff    <= clip_ff || clip_now || report_clip;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stack_offset  = rsp_offset_ff;
   assign rsp_pc_was_popped = rsp_pc_ff;
   assign rsp_saturated     = rsp_sat_ff;

`ifndef NO_ASSERTIONS
   // A new result only follows a last word held in the input register.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall))
         |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result appeared without a last word");

   // The state is clear after a range has been closed.
   a_range_clear: assert property (@(posedge clock) disable iff (reset)
      (drain && s1_last_ff) |=> (run_ff == '0 && low_ff == '0 && !pc_ff && !clip_ff))
      else $error("state not cleared after a range");

   // The lowest offset never lies above the running offset.
   a_low_bound: assert property (@(posedge clock) disable iff (reset)
      low_ff <= run_ff)
      else $error("lowest offset above running offset");

   // A held result is never overwritten by a last word.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(drain && s1_last_ff))
      else $error("held result overwritten");
`endif

endmodule
